@@ sv/apu_pkg.sv @@
`default_nettype none

package apu_pkg;

  localparam int NumParams  = 16384;
  localparam int AddrW      = $clog2(NumParams);
  localparam int FracBits   = 24;
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  localparam logic [24:0] OneQ24 = 25'h1000000;
  localparam logic [32:0] EpsQ   =
      33'(((64'd1 << FracBits) + 64'd5000000) / 64'd10000000);

  localparam logic [1:0] CfgLearningRate = 2'd0;
  localparam logic [1:0] CfgFirstDecay   = 2'd1;
  localparam logic [1:0] CfgSecondDecay  = 2'd2;

  typedef struct packed {
    logic [13:0]        element_index;
    logic signed [31:0] param_value;
    logic signed [31:0] gradient;
    logic               last_of_pass;
  } apu_in_t;

  typedef struct packed {
    logic signed [31:0] new_param_value;
    logic [13:0]        out_index;
    logic               saturated;
  } apu_out_t;

  typedef struct packed {
    logic [23:0] learning_rate;
    logic [23:0] first_decay;
    logic [23:0] second_decay;
  } apu_cfg_t;

  typedef struct packed {
    logic [13:0]        idx;
    logic signed [31:0] x;
    logic signed [31:0] g;
    logic [24:0]        c1;
    logic [24:0]        c2;
  } apu_item_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] lo;
    logic [33:0] den;
    logic [31:0] quo;
  } div_st_t;

  // One bit of a restoring square root: two radicand bits enter per step.
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
    sqrt_st_t    r;
    logic [33:0] t;
    logic [33:0] trial;
    t     = {s.rem[31:0], s.rad[63:62]};
    trial = {s.root, 2'b01};
    r.rad = {s.rad[61:0], 2'b00};
    if (t >= trial) begin
      r.rem  = t - trial;
      r.root = {s.root[30:0], 1'b1};
    end else begin
      r.rem  = t;
      r.root = {s.root[30:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of a restoring division.
  function automatic div_st_t div_step(div_st_t s);
    div_st_t     r;
    logic [33:0] t;
    t     = {s.rem[32:0], s.lo[31]};
    r.lo  = {s.lo[30:0], 1'b0};
    r.den = s.den;
    if (t >= s.den) begin
      r.rem = t - s.den;
      r.quo = {s.quo[30:0], 1'b1};
    end else begin
      r.rem = t;
      r.quo = {s.quo[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/apu_front.sv @@
`default_nettype none

module apu_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  apu_pkg::apu_in_t    in_data_i,
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire  [1:0]          cfg_index_i,
  input  wire  [23:0]         cfg_data_i,
  input  wire                 clr_done_i,
  input  wire                 q_ready_i,
  output logic                q_push_o,
  output apu_pkg::apu_item_t  q_item_o,
  output apu_pkg::apu_cfg_t   cfg_o
);
  import apu_pkg::*;

  apu_cfg_t    cfg_q;
  logic [24:0] bp1_q, bp2_q;
  logic [48:0] prod1, prod2;
  logic [48:0] rnd1, rnd2;
  logic [24:0] p1, p2;
  logic        accept;

  assign in_ready_o  = q_ready_i && clr_done_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  assign prod1 = bp1_q * cfg_q.first_decay;
  assign prod2 = bp2_q * cfg_q.second_decay;
  assign rnd1  = prod1 + 49'd8388608;
  assign rnd2  = prod2 + 49'd8388608;
  assign p1    = rnd1[48:24];
  assign p2    = rnd2[48:24];

  assign q_push_o      = accept;
  assign q_item_o.idx  = in_data_i.element_index;
  assign q_item_o.x    = in_data_i.param_value;
  assign q_item_o.g    = in_data_i.gradient;
  assign q_item_o.c1   = OneQ24 - p1;
  assign q_item_o.c2   = OneQ24 - p2;
  assign cfg_o         = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.learning_rate <= 24'd16777;
      cfg_q.first_decay   <= 24'd15099494;
      cfg_q.second_decay  <= 24'd16760439;
      bp1_q               <= OneQ24;
      bp2_q               <= OneQ24;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgLearningRate: cfg_q.learning_rate <= cfg_data_i;
          CfgFirstDecay:   cfg_q.first_decay   <= cfg_data_i;
          CfgSecondDecay:  cfg_q.second_decay  <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && in_data_i.last_of_pass) begin
        bp1_q <= p1;
        bp2_q <= p2;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/apu_queue.sv @@
`default_nettype none

module apu_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  apu_pkg::apu_item_t  item_i,
  output logic                ready_o,
  output logic                valid_o,
  output apu_pkg::apu_item_t  item_o,
  input  wire                 pop_i
);
  import apu_pkg::*;

  apu_item_t          entry_q [QueueDepth];
  logic [QueueAw-1:0] wr_q, rd_q;
  logic [QueueAw:0]   cnt_q;

  assign ready_o = cnt_q != (QueueAw+1)'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign item_o  = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/apu_back.sv @@
`default_nettype none

module apu_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  apu_pkg::apu_cfg_t   cfg_i,
  input  wire                 q_valid_i,
  input  apu_pkg::apu_item_t  q_item_i,
  output logic                q_pop_o,
  output logic                clr_done_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output apu_pkg::apu_out_t   out_data_o
);
  import apu_pkg::*;

  typedef struct packed {
    logic [13:0]        idx;
    logic signed [31:0] x;
    logic [24:0]        c1;
    logic [24:0]        c2;
    logic signed [56:0] pm1;
    logic signed [57:0] pm2;
    logic [63:0]        gg;
    logic [47:0]        pv_hi;
    logic [47:0]        pv_lo;
  } s2_t;

  typedef struct packed {
    logic [13:0]        idx;
    logic signed [31:0] x;
    logic [24:0]        c1;
    logic [24:0]        c2;
    logic [31:0]        m;
    logic               sat;
    logic [47:0]        g2;
    logic [47:0]        pv_hi;
    logic [47:0]        pv_lo;
  } s3_t;

  typedef struct packed {
    logic [13:0]        idx;
    logic signed [31:0] x;
    logic               sat;
    logic               neg;
    logic [31:0]        mag;
    logic [24:0]        c1;
    sqrt_st_t           sd;
    sqrt_st_t           ss;
  } sqa_t;

  typedef struct packed {
    logic [13:0]        idx;
    logic signed [31:0] x;
    logic               sat;
    logic               neg;
    logic [31:0]        mag;
    logic [24:0]        c1;
    logic [32:0]        d;
    logic [48:0]        pl;
  } t1_t;

  typedef struct packed {
    logic [13:0]        idx;
    logic signed [31:0] x;
    logic               sat;
    logic               neg;
    logic               ovr;
    logic               ovl;
    div_st_t            dr;
    div_st_t            dl;
  } dvb_t;

  typedef struct packed {
    logic [13:0]        idx;
    logic signed [31:0] x;
    logic               sat;
    logic               neg;
    logic [63:0]        prod;
  } mul_t;

  function automatic sqa_t sqa_adv(sqa_t s);
    sqa_t r;
    r    = s;
    r.sd = sqrt_step(s.sd);
    r.ss = sqrt_step(s.ss);
    return r;
  endfunction

  function automatic dvb_t dvb_adv(dvb_t s);
    dvb_t r;
    r    = s;
    r.dr = div_step(s.dr);
    r.dl = div_step(s.dl);
    return r;
  endfunction

  logic signed [31:0] mem_m [NumParams];
  logic [47:0]        mem_v [NumParams];
  logic signed [31:0] rd_m_q;
  logic [47:0]        rd_v_q;

  logic [AddrW:0]     clr_q;
  logic               en;
  logic               hazard;
  logic               pop;

  apu_item_t s1_q;
  s2_t       s2_q, s2_d;
  s3_t       s3_q, s3_d;
  sqa_t      a_q [33];
  sqa_t      a0_d;
  t1_t       t1_q, t1_d;
  dvb_t      b_q [33];
  dvb_t      b0_d;
  mul_t      m_q, m_d;
  apu_out_t  out_q, out_d;

  logic        s1_v_q, s2_v_q, s3_v_q, t1_v_q, m_v_q, out_valid_q;
  logic [32:0] a_v_q, b_v_q;

  logic        wr_en;
  logic [AddrW-1:0] wr_addr;
  logic signed [31:0] wr_m;
  logic [47:0] wr_v;

  assign clr_done_o  = clr_q[AddrW];
  assign en          = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign hazard = (s1_v_q && s1_q.idx[AddrW-1:0] == q_item_i.idx[AddrW-1:0]) ||
                  (s2_v_q && s2_q.idx[AddrW-1:0] == q_item_i.idx[AddrW-1:0]) ||
                  (s3_v_q && s3_q.idx[AddrW-1:0] == q_item_i.idx[AddrW-1:0]);
  assign pop     = en && clr_done_o && q_valid_i && !hazard;
  assign q_pop_o = pop;

  // First stage: moment products.
  logic [24:0] nb1, nb2;
  assign nb1 = OneQ24 - {1'b0, cfg_i.first_decay};
  assign nb2 = OneQ24 - {1'b0, cfg_i.second_decay};

  always_comb begin
    s2_d.idx   = s1_q.idx;
    s2_d.x     = s1_q.x;
    s2_d.c1    = s1_q.c1;
    s2_d.c2    = s1_q.c2;
    s2_d.pm1   = $signed({1'b0, cfg_i.first_decay}) * rd_m_q;
    s2_d.pm2   = $signed({1'b0, nb1}) * s1_q.g;
    s2_d.gg    = 64'(s1_q.g * s1_q.g);
    s2_d.pv_hi = rd_v_q[47:24] * cfg_i.second_decay;
    s2_d.pv_lo = rd_v_q[23:0] * cfg_i.second_decay;
  end

  // Second stage: first moment and squared gradient.
  logic [58:0] mt;
  logic [34:0] m35;
  logic [63:0] g2sum;
  logic        movf;
  assign mt    = {{2{s2_q.pm1[56]}}, s2_q.pm1} + {s2_q.pm2[57], s2_q.pm2} + 59'd8388608;
  assign m35   = mt[58:24];
  assign movf  = !(m35[34:31] == 4'b0000 || m35[34:31] == 4'b1111);
  assign g2sum = s2_q.gg + 64'd32768;

  always_comb begin
    s3_d.idx   = s2_q.idx;
    s3_d.x     = s2_q.x;
    s3_d.c1    = s2_q.c1;
    s3_d.c2    = s2_q.c2;
    s3_d.sat   = movf;
    s3_d.m     = movf ? (m35[34] ? 32'h80000000 : 32'h7fffffff) : m35[31:0];
    s3_d.g2    = g2sum[63:16];
    s3_d.pv_hi = s2_q.pv_hi;
    s3_d.pv_lo = s2_q.pv_lo;
  end

  // Third stage: second moment, store write-back and root setup.
  logic [48:0] pg_hi, pg_lo;
  logic [49:0] vhi, vlo;
  logic [50:0] vs;
  logic        vovf;
  logic [47:0] vnew;
  logic        mneg;
  assign pg_hi = s3_q.g2[47:24] * nb2;
  assign pg_lo = s3_q.g2[23:0] * nb2;
  assign vhi   = 50'(s3_q.pv_hi) + 50'(pg_hi);
  assign vlo   = 50'(s3_q.pv_lo) + 50'(pg_lo) + 50'd8388608;
  assign vs    = 51'(vhi) + 51'(vlo[49:24]);
  assign vovf  = |vs[50:48];
  assign vnew  = vovf ? '1 : vs[47:0];
  assign mneg  = s3_q.m[31];

  always_comb begin
    a0_d.idx     = s3_q.idx;
    a0_d.x       = s3_q.x;
    a0_d.sat     = s3_q.sat || vovf;
    a0_d.neg     = mneg;
    a0_d.mag     = mneg ? (32'd0 - s3_q.m) : s3_q.m;
    a0_d.c1      = s3_q.c1;
    a0_d.sd.rad  = {vnew, 16'h0000};
    a0_d.sd.rem  = '0;
    a0_d.sd.root = '0;
    a0_d.ss.rad  = {15'd0, s3_q.c2, 24'd0};
    a0_d.ss.rem  = '0;
    a0_d.ss.root = '0;
  end

  // Denominator and scaled rate numerator.
  logic [32:0] dsum;
  always_comb begin
    dsum      = {1'b0, a_q[32].sd.root} + EpsQ;
    t1_d.idx  = a_q[32].idx;
    t1_d.x    = a_q[32].x;
    t1_d.sat  = a_q[32].sat;
    t1_d.neg  = a_q[32].neg;
    t1_d.mag  = a_q[32].mag;
    t1_d.c1   = a_q[32].c1;
    t1_d.d    = (dsum == '0) ? 33'd1 : dsum;
    t1_d.pl   = cfg_i.learning_rate * a_q[32].ss.root[24:0];
  end

  // Division setup with overflow detection.
  logic [56:0] numr;
  logic [49:0] numl;
  assign numr = {1'b0, t1_q.mag, 24'd0} + 57'(t1_q.d[32:1]);
  assign numl = {1'b0, t1_q.pl} + 50'(t1_q.c1[24:1]);

  always_comb begin
    b0_d.idx    = t1_q.idx;
    b0_d.x      = t1_q.x;
    b0_d.sat    = t1_q.sat;
    b0_d.neg    = t1_q.neg;
    b0_d.ovr    = 65'(numr) >= {t1_q.d, 32'd0};
    b0_d.ovl    = 57'(numl) >= {t1_q.c1, 32'd0};
    b0_d.dr.rem = 34'(numr[56:32]);
    b0_d.dr.lo  = numr[31:0];
    b0_d.dr.den = {1'b0, t1_q.d};
    b0_d.dr.quo = '0;
    b0_d.dl.rem = 34'(numl[49:32]);
    b0_d.dl.lo  = numl[31:0];
    b0_d.dl.den = 34'(t1_q.c1);
    b0_d.dl.quo = '0;
  end

  logic [31:0] rq, lq;
  assign rq = b_q[32].ovr ? '1 : b_q[32].dr.quo;
  assign lq = b_q[32].ovl ? '1 : b_q[32].dl.quo;

  always_comb begin
    m_d.idx  = b_q[32].idx;
    m_d.x    = b_q[32].x;
    m_d.sat  = b_q[32].sat || b_q[32].ovr || b_q[32].ovl;
    m_d.neg  = b_q[32].neg;
    m_d.prod = lq * rq;
  end

  // Step rounding and parameter update.
  logic [64:0] stp_sum;
  logic [42:0] xs, st, res;
  logic        rovf;
  assign stp_sum = {1'b0, m_q.prod} + 65'd8388608;
  assign xs      = {{11{m_q.x[31]}}, m_q.x};
  assign st      = {2'b00, stp_sum[64:24]};
  assign res     = m_q.neg ? (xs + st) : (xs - st);
  assign rovf    = !(res[42:31] == 12'h000 || res[42:31] == 12'hfff);

  always_comb begin
    out_d.new_param_value = rovf ? (res[42] ? 32'sh80000000 : 32'sh7fffffff)
                                 : $signed(res[31:0]);
    out_d.out_index       = m_q.idx;
    out_d.saturated       = m_q.sat || rovf;
  end

  assign wr_en   = !clr_done_o || (s3_v_q && en);
  assign wr_addr = clr_done_o ? s3_q.idx[AddrW-1:0] : clr_q[AddrW-1:0];
  assign wr_m    = clr_done_o ? s3_q.m : '0;
  assign wr_v    = clr_done_o ? vnew : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_m[wr_addr] <= wr_m;
      mem_v[wr_addr] <= wr_v;
    end
    if (pop) begin
      rd_m_q <= mem_m[q_item_i.idx[AddrW-1:0]];
      rd_v_q <= mem_v[q_item_i.idx[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      a_v_q       <= '0;
      t1_v_q      <= 1'b0;
      b_v_q       <= '0;
      m_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!clr_done_o) begin
        clr_q <= clr_q + 1'b1;
      end
      if (en) begin
        s1_v_q      <= pop;
        s2_v_q      <= s1_v_q;
        s3_v_q      <= s2_v_q;
        a_v_q       <= {a_v_q[31:0], s3_v_q};
        t1_v_q      <= a_v_q[32];
        b_v_q       <= {b_v_q[31:0], t1_v_q};
        m_v_q       <= b_v_q[32];
        out_valid_q <= m_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_q <= q_item_i;
    end
    if (en) begin
      s2_q   <= s2_d;
      s3_q   <= s3_d;
      a_q[0] <= a0_d;
      for (int k = 0; k < 32; k++) begin
        a_q[k+1] <= sqa_adv(a_q[k]);
      end
      t1_q   <= t1_d;
      b_q[0] <= b0_d;
      for (int k = 0; k < 32; k++) begin
        b_q[k+1] <= dvb_adv(b_q[k]);
      end
      m_q    <= m_d;
      out_q  <= out_d;
    end
  end

`ifndef SYNTH
  a_pop_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> clr_done_o)
    else $error("Request taken from the queue during the clearing pass.");

  a_clear_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_done_o |=> clr_done_o)
    else $error("Clearing pass restarted without reset.");

  a_no_work_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_done_o |-> !(s1_v_q || s3_v_q || out_valid_q))
    else $error("Request in flight during the clearing pass.");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> ($stable(a_v_q) && $stable(b_v_q)))
    else $error("Pipeline moved while the output was stalled.");
`endif

endmodule

`default_nettype wire

@@ sv/adam_parameter_update_core.sv @@
// Adam optimizer update engine, one parameter per request.
// Input channel (in_valid_i/in_ready_o) takes an element index, the parameter
// and its gradient in signed Q8.24, plus a flag that closes an update pass.
// Output channel (out_valid_o/out_ready_i) returns the updated parameter,
// the echoed index and a saturation flag, one result per request, in order.
// The configuration channel writes learning rate and both decays; it is
// always ready and should only be used while no request is in flight.
// Throughput is one request per cycle while the receiver does not stall and
// no element hazard holds the queue head. Each request passes through the
// two 32-step square roots, computed side by side, and then the two 32-step
// divisions of the back pipeline. A request whose element matches one still
// in the three-stage moment read-modify-write waits in the queue until that
// write completes. After reset a clearing pass zeroes all 16384 entries of
// both moment stores; in_ready_o stays low until it finishes. Bias powers
// restart at 1.0. When the receiver stalls, the back pipeline holds and the
// four-entry queue keeps accepting requests until it fills.
`default_nettype none

module adam_parameter_update_core (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  apu_pkg::apu_in_t   in_data_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output apu_pkg::apu_out_t  out_data_o,
  input  wire                cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire  [1:0]         cfg_index_i,
  input  wire  [23:0]        cfg_data_i
);
  import apu_pkg::*;

  apu_item_t push_item, head_item;
  apu_cfg_t  cfg;
  logic      push, q_ready, q_valid, pop, clr_done;

  apu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .clr_done_i  (clr_done),
    .q_ready_i   (q_ready),
    .q_push_o    (push),
    .q_item_o    (push_item),
    .cfg_o       (cfg)
  );

  apu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .item_o  (head_item),
    .pop_i   (pop)
  );

  apu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_item_i    (head_item),
    .q_pop_o     (pop),
    .clr_done_o  (clr_done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import apu_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  apu_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  apu_out_t out_data_o;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [23:0] cfg_data_i;

  adam_parameter_update_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  longint          moment1_m [NumParams];
  longint unsigned moment2_m [NumParams];
  longint unsigned pow1_q, pow2_q;
  longint unsigned rate_q, decay1_q, decay2_q;

  apu_in_t  request_q [$];
  apu_out_t updated_q [$];

  int  send_idle_pct, recv_idle_pct;
  int  accepted_cnt;
  int  hold_cnt;
  bit  hold_done;
  bit  failed;
  int  cycle_cnt;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic apu_out_t adam_step_predict(apu_in_t it);
    apu_out_t        o;
    int              a;
    longint          x, g, mt, m, res;
    longint unsigned b1, b2, nb, g2, hi, lo, v, p1, p2, c1, c2, s2, lrt;
    longint unsigned mag, d, r, step;
    bit              sat, neg;
    a   = int'(it.element_index) % NumParams;
    x   = longint'(it.param_value);
    g   = longint'(it.gradient);
    b1  = decay1_q;
    b2  = decay2_q;
    sat = 1'b0;

    mt = longint'(b1) * moment1_m[a] + longint'(64'd16777216 - b1) * g + 64'sd8388608;
    m  = mt >>> 24;
    if (m > 64'sd2147483647) begin m = 64'sd2147483647; sat = 1'b1; end
    if (m < -64'sd2147483648) begin m = -64'sd2147483648; sat = 1'b1; end

    g2 = (longint'(g * g) + 64'd32768) >> 16;
    nb = 64'd16777216 - b2;
    hi = (moment2_m[a] >> 24) * b2 + (g2 >> 24) * nb;
    lo = (moment2_m[a] & 64'hFFFFFF) * b2 + (g2 & 64'hFFFFFF) * nb + 64'd8388608;
    v  = hi + (lo >> 24);
    if (v > 64'hFFFF_FFFF_FFFF) begin v = 64'hFFFF_FFFF_FFFF; sat = 1'b1; end

    p1 = (pow1_q * b1 + 64'd8388608) >> 24;
    p2 = (pow2_q * b2 + 64'd8388608) >> 24;
    c1 = (p1 >= 64'd16777216) ? 64'd1 : 64'd16777216 - p1;
    c2 = (p2 >= 64'd16777216) ? 64'd0 : 64'd16777216 - p2;
    s2 = int_sqrt(c2 << 24);
    lrt = (rate_q * s2 + c1 / 2) / c1;
    if (lrt > 64'hFFFFFFFF) begin lrt = 64'hFFFFFFFF; sat = 1'b1; end

    neg = m < 0;
    mag = neg ? longint'(-m) : longint'(m);
    d   = int_sqrt(v << 16) + longint'(EpsQ);
    if (d == 0) d = 1;
    r = ((mag << FracBits) + d / 2) / d;
    if (r > 64'hFFFFFFFF) begin r = 64'hFFFFFFFF; sat = 1'b1; end

    step = (lrt * r + 64'd8388608) >> 24;
    res  = neg ? x + longint'(step) : x - longint'(step);
    if (res > 64'sd2147483647) begin res = 64'sd2147483647; sat = 1'b1; end
    if (res < -64'sd2147483648) begin res = -64'sd2147483648; sat = 1'b1; end

    moment1_m[a] = m;
    moment2_m[a] = v;
    if (it.last_of_pass) begin
      pow1_q = p1;
      pow2_q = p2;
    end
    o.new_param_value = res[31:0];
    o.out_index       = it.element_index;
    o.saturated       = sat;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        updated_q.push_back(adam_step_predict(in_data_i));
        accepted_cnt = accepted_cnt + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= request_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (!hold_done && accepted_cnt >= 250) begin
        hold_done = 1'b1;
        hold_cnt  = 400;
      end
      if (hold_cnt > 0) begin
        hold_cnt = hold_cnt - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    apu_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (updated_q.size() == 0) begin
        $display("%t: unexpected result %p", $time, out_data_o);
        failed = 1'b1;
      end else begin
        want = updated_q.pop_front();
        if (want.new_param_value !== out_data_o.new_param_value ||
            want.out_index !== out_data_o.out_index ||
            want.saturated !== out_data_o.saturated) begin
          $display("%t: expected %p, actual %p", $time, want, out_data_o);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > 600000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CfgLearningRate: rate_q   = val;
      CfgFirstDecay:   decay1_q = val;
      CfgSecondDecay:  decay2_q = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [23:0] lr, logic [23:0] b1, logic [23:0] b2);
    write_reg(CfgLearningRate, lr);
    write_reg(CfgFirstDecay, b1);
    write_reg(CfgSecondDecay, b2);
  endtask

  task automatic add_request(int idx, longint x, longint g, bit last);
    apu_in_t it;
    it.element_index = idx[13:0];
    it.param_value   = x[31:0];
    it.gradient      = g[31:0];
    it.last_of_pass  = last;
    request_q.push_back(it);
  endtask

  task automatic add_random(int n);
    int     idx;
    longint x, g;
    repeat (n) begin
      idx = ($urandom_range(99) < 70) ? $urandom_range(31) : $urandom_range(16383);
      x = ($urandom_range(3) == 0) ? longint'($signed($urandom()))
                                   : longint'($signed($urandom_range(0, 32'h07FF_FFFF)))
                                     - 64'sd67108864;
      case ($urandom_range(3))
        0: g = longint'($signed($urandom()));
        1: g = longint'($urandom_range(0, 32'h01FF_FFFF)) - 64'sd16777216;
        2: g = longint'($urandom_range(0, 2047)) - 64'sd1024;
        default: g = longint'($urandom_range(0, 32'h001F_FFFF)) - 64'sd1048576;
      endcase
      add_request(idx, x, g, $urandom_range(15) == 0);
    end
  endtask

  task automatic drain();
    while (request_q.size() > 0 || in_valid_i || updated_q.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    failed       = 1'b0;
    cycle_cnt    = 0;
    accepted_cnt = 0;
    hold_cnt     = 0;
    hold_done    = 1'b0;
    send_idle_pct = 18;
    recv_idle_pct = 52;
    for (int i = 0; i < NumParams; i++) begin
      moment1_m[i] = 0;
      moment2_m[i] = 0;
    end
    pow1_q   = 64'd16777216;
    pow2_q   = 64'd16777216;
    rate_q   = 16777;
    decay1_q = 15099494;
    decay2_q = 16760439;
    repeat (8) @(posedge clk_i);
    rst_ni = 1'b1;

    set_config(24'd16777, 24'd15099494, 24'd16760439);
    add_request(0, 0, 0, 1'b0);
    add_request(16383, 64'sd2147483647, 64'sd2147483647, 1'b0);
    add_request(16383, -64'sd2147483648, -64'sd2147483648, 1'b0);
    add_request(16383, 64'sd2147483647, -64'sd2147483648, 1'b1);
    add_request(1, -64'sd2147483648, 64'sd2147483647, 1'b0);
    add_request(1, 64'sd16777216, 64'sd16777216, 1'b0);
    add_request(1, 64'sd16777216, 64'sd16777216, 1'b0);
    add_request(2, -64'sd16777216, -64'sd1, 1'b1);
    add_request(10922, 64'sd1, 64'sd1, 1'b0);
    add_request(5461, -64'sd1, -64'sd2, 1'b1);
    add_request(3, 64'sd5, 0, 1'b0);
    add_request(3, 64'sd5, 64'sd2147483647, 1'b0);
    add_request(3, 64'sd2147483600, -64'sd2147483648, 1'b0);
    add_request(3, -64'sd2147483600, 64'sd2147483647, 1'b1);
    add_random(313);
    drain();

    set_config(24'hFFFFFF, 24'd0, 24'd0);
    add_request(7, 0, 64'sd2147483647, 1'b1);
    add_request(7, 0, -64'sd2147483648, 1'b1);
    add_random(200);
    drain();

    send_idle_pct = 52;
    recv_idle_pct = 18;
    set_config(24'd0, 24'hFFFFFF, 24'hFFFFFF);
    add_request(9, 64'sd100, 64'sd2147483647, 1'b1);
    add_random(200);
    drain();

    set_config(24'($urandom()), 24'($urandom()), 24'($urandom()));
    add_random(200);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(24'($urandom_range(1, 1000000)), 24'd15099494, 24'hFFFFFF);
    add_random(120);
    drain();
    set_config(24'hFFFFFF, 24'hFFFFFF, 24'd1);
    add_random(100);
    drain();

    if (!failed) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
